/* rtl/rotate_points_about_center_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the point rotation core
// Shorthand for clocked assertions with asynchronous reset masking.
// ----------------------------------------------------------------------------
`ifndef ROTATE_POINTS_ABOUT_CENTER_CORE_ASSERT_SVH
`define ROTATE_POINTS_ABOUT_CENTER_CORE_ASSERT_SVH

// Same-cycle implication
`define RPAC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define RPAC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/rpac_pkg.sv */
// ----------------------------------------------------------------------------
// Point rotation package
// Widths, register indexes and the saturation helper for the rotation core.
// ----------------------------------------------------------------------------
package rpac_pkg;

	// Field and datapath widths
	localparam int COORD_W  = 32;
	localparam int FRAC_W   = 16;
	localparam int TRIG_W   = FRAC_W + 2;
	localparam int CENTRE_W = COORD_W - 1;
	localparam int DIFF_W   = COORD_W + 1;
	localparam int PROD_W   = DIFF_W + TRIG_W;
	localparam int SUM_W    = PROD_W + 1;
	localparam int SHR_W    = SUM_W - FRAC_W;
	localparam int ACC_W    = SHR_W + 1;

	// Stream and configuration port widths
	localparam int TDATA_W    = 3 * COORD_W;
	localparam int CFG_DATA_W = COORD_W;
	localparam int CFG_IDX_W  = 3;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COS_Y  = 3'd0,
		REG_SIN_Y  = 3'd1,
		REG_COS_X  = 3'd2,
		REG_SIN_X  = 3'd3,
		REG_SHIFT_X = 3'd4,
		REG_SHIFT_Y = 3'd5,
		REG_SHIFT_Z = 3'd6,
		REG_CENTRE = 3'd7
	} cfg_reg_t;

	// Reset value of a cosine: 1.0 in Q1.16
	localparam logic signed [TRIG_W-1:0] TRIG_ONE = TRIG_W'(1) <<< FRAC_W;

	typedef struct packed {
		logic                      clipped;
		logic signed [COORD_W-1:0] val;
	} sat_res_t;

	// Clamp a wide value to the coordinate range and report clipping
	function automatic sat_res_t sat_coord(input logic signed [ACC_W-1:0] v);
		sat_res_t r;
		logic     in_range;
		in_range = (v[ACC_W-1:COORD_W-1] == {(ACC_W-COORD_W+1){1'b0}}) ||
		           (v[ACC_W-1:COORD_W-1] == {(ACC_W-COORD_W+1){1'b1}});
		if (in_range) begin
			r.clipped = 1'b0;
			r.val     = v[COORD_W-1:0];
		end else begin
			r.clipped = 1'b1;
			r.val     = v[ACC_W-1] ? {1'b1, {(COORD_W-1){1'b0}}}
			                       : {1'b0, {(COORD_W-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

/* rtl/rotate_points_about_center_core.sv */
// ----------------------------------------------------------------------------
// Point shift and rotation core
// Shifts a Q15.16 point, rotates it about the cube centre around y, then x.
// ----------------------------------------------------------------------------
// Each item is one point; it is shifted per axis, rotated about (c, c, c)
// around the y axis and then around the x axis, with products truncated
// toward minus infinity and every shifted or rotated coordinate clamped to
// 32 bits (tuser flags any clamp). The core takes one point per clock while
// the output is not stalled, through a nine-stage pipeline whose first stage
// loads at acceptance and whose ninth stage is the output register; each
// stage advances when it is empty or the stage after it moves, so bubbles
// close up and input is taken while a result waits at the output. The
// input ready follows the output ready combinationally along that chain.
// Write the configuration registers only while no point is in flight.
`include "rotate_points_about_center_core_assert.svh"

module rotate_points_about_center_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration write port
	input  logic                                  cfg_we,
	input  logic [rpac_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [rpac_pkg::CFG_DATA_W-1:0]       cfg_data,
	// input points
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  logic [rpac_pkg::TDATA_W-1:0]          s_axis_tdata,  // pos_x, pos_y, pos_z
	// rotated points
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	output logic [rpac_pkg::TDATA_W-1:0]          m_axis_tdata,  // new_x, new_y, new_z
	output logic                                  m_axis_tuser   // saturated
);
	import rpac_pkg::*;

	// Configuration registers
	logic signed [TRIG_W-1:0]   cos_y_q, sin_y_q, cos_x_q, sin_x_q;
	logic signed [COORD_W-1:0]  shift_x_q, shift_y_q, shift_z_q;
	logic        [CENTRE_W-1:0] centre_q;

	// Stage valids and advance enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7, en_s8, en_s9;

	// Stage payloads
	logic signed [COORD_W-1:0] xs_s1, ys_s1, zs_s1;
	logic                      sat_s1;
	logic signed [DIFF_W-1:0]  dx_s2, dy_s2, dz_s2;
	logic                      sat_s2;
	logic signed [PROD_W-1:0]  pxc_s3, pzs_s3, pzc_s3, pxs_s3;
	logic signed [DIFF_W-1:0]  dy_s3;
	logic                      sat_s3;
	logic signed [SUM_W-1:0]   sx_s4, sz_s4;
	logic signed [DIFF_W-1:0]  dy_s4;
	logic                      sat_s4;
	logic signed [COORD_W-1:0] x1_s5, z1_s5;
	logic signed [DIFF_W-1:0]  dy_s5;
	logic                      sat_s5;
	logic signed [COORD_W-1:0] x1_s6;
	logic signed [DIFF_W-1:0]  dy_s6, dz1_s6;
	logic                      sat_s6;
	logic signed [COORD_W-1:0] x1_s7;
	logic signed [PROD_W-1:0]  pyc_s7, pzs_s7, pzc_s7, pys_s7;
	logic                      sat_s7;
	logic signed [COORD_W-1:0] x1_s8;
	logic signed [SUM_W-1:0]   sy_s8, sz_s8;
	logic                      sat_s8;
	logic signed [COORD_W-1:0] x_s9, y_s9, z_s9;
	logic                      sat_s9;

	// Combinational helpers
	logic signed [DIFF_W-1:0]  centre_ext;
	logic signed [COORD_W-1:0] pos_x, pos_y, pos_z;
	sat_res_t                  sxs, sys, szs, sx1, sz1, sy2, sz2;

	assign centre_ext = {2'b00, centre_q};
	assign pos_x      = s_axis_tdata[COORD_W-1:0];
	assign pos_y      = s_axis_tdata[2*COORD_W-1:COORD_W];
	assign pos_z      = s_axis_tdata[3*COORD_W-1:2*COORD_W];

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_y_q   <= TRIG_ONE;
			sin_y_q   <= '0;
			cos_x_q   <= TRIG_ONE;
			sin_x_q   <= '0;
			shift_x_q <= '0;
			shift_y_q <= '0;
			shift_z_q <= '0;
			centre_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_COS_Y:   cos_y_q   <= cfg_data[TRIG_W-1:0];
				REG_SIN_Y:   sin_y_q   <= cfg_data[TRIG_W-1:0];
				REG_COS_X:   cos_x_q   <= cfg_data[TRIG_W-1:0];
				REG_SIN_X:   sin_x_q   <= cfg_data[TRIG_W-1:0];
				REG_SHIFT_X: shift_x_q <= cfg_data[COORD_W-1:0];
				REG_SHIFT_Y: shift_y_q <= cfg_data[COORD_W-1:0];
				REG_SHIFT_Z: shift_z_q <= cfg_data[COORD_W-1:0];
				REG_CENTRE:  centre_q  <= cfg_data[CENTRE_W-1:0];
				default: ;
			endcase
		end
	end

	// Advance a stage when it is empty or its successor advances
	assign en_s9 = !v_s9 || m_axis_tready;
	assign en_s8 = !v_s8 || en_s9;
	assign en_s7 = !v_s7 || en_s8;
	assign en_s6 = !v_s6 || en_s7;
	assign en_s5 = !v_s5 || en_s6;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;

	assign s_axis_tready = en_s1;

	// Move valid bits along the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= s_axis_tvalid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
			if (en_s7) v_s7 <= v_s6;
			if (en_s8) v_s8 <= v_s7;
			if (en_s9) v_s9 <= v_s8;
		end
	end

	// Clamp the shifted and rotated coordinates
	always_comb begin
		sxs = sat_coord(ACC_W'({{(ACC_W-COORD_W){pos_x[COORD_W-1]}}, pos_x}) +
		                ACC_W'({{(ACC_W-COORD_W){shift_x_q[COORD_W-1]}}, shift_x_q}));
		sys = sat_coord(ACC_W'({{(ACC_W-COORD_W){pos_y[COORD_W-1]}}, pos_y}) +
		                ACC_W'({{(ACC_W-COORD_W){shift_y_q[COORD_W-1]}}, shift_y_q}));
		szs = sat_coord(ACC_W'({{(ACC_W-COORD_W){pos_z[COORD_W-1]}}, pos_z}) +
		                ACC_W'({{(ACC_W-COORD_W){shift_z_q[COORD_W-1]}}, shift_z_q}));
		sx1 = sat_coord({sx_s4[SUM_W-1], sx_s4[SUM_W-1:FRAC_W]} +
		                {{(ACC_W-CENTRE_W){1'b0}}, centre_q});
		sz1 = sat_coord({sz_s4[SUM_W-1], sz_s4[SUM_W-1:FRAC_W]} +
		                {{(ACC_W-CENTRE_W){1'b0}}, centre_q});
		sy2 = sat_coord({sy_s8[SUM_W-1], sy_s8[SUM_W-1:FRAC_W]} +
		                {{(ACC_W-CENTRE_W){1'b0}}, centre_q});
		sz2 = sat_coord({sz_s8[SUM_W-1], sz_s8[SUM_W-1:FRAC_W]} +
		                {{(ACC_W-CENTRE_W){1'b0}}, centre_q});
	end

	// Stage 1: shift and clamp
	always_ff @(posedge clk) begin
		if (en_s1) begin
			xs_s1  <= sxs.val;
			ys_s1  <= sys.val;
			zs_s1  <= szs.val;
			sat_s1 <= sxs.clipped || sys.clipped || szs.clipped;
		end
	end

	// Stage 2: offsets from the centre
	always_ff @(posedge clk) begin
		if (en_s2) begin
			dx_s2  <= {xs_s1[COORD_W-1], xs_s1} - centre_ext;
			dy_s2  <= {ys_s1[COORD_W-1], ys_s1} - centre_ext;
			dz_s2  <= {zs_s1[COORD_W-1], zs_s1} - centre_ext;
			sat_s2 <= sat_s1;
		end
	end

	// Stage 3: products for the y rotation
	always_ff @(posedge clk) begin
		if (en_s3) begin
			pxc_s3 <= dx_s2 * cos_y_q;
			pzs_s3 <= dz_s2 * sin_y_q;
			pzc_s3 <= dz_s2 * cos_y_q;
			pxs_s3 <= dx_s2 * sin_y_q;
			dy_s3  <= dy_s2;
			sat_s3 <= sat_s2;
		end
	end

	// Stage 4: sums for the y rotation
	always_ff @(posedge clk) begin
		if (en_s4) begin
			sx_s4  <= {pxc_s3[PROD_W-1], pxc_s3} + {pzs_s3[PROD_W-1], pzs_s3};
			sz_s4  <= {pzc_s3[PROD_W-1], pzc_s3} - {pxs_s3[PROD_W-1], pxs_s3};
			dy_s4  <= dy_s3;
			sat_s4 <= sat_s3;
		end
	end

	// Stage 5: truncate, recenter and clamp x1, z1
	always_ff @(posedge clk) begin
		if (en_s5) begin
			x1_s5  <= sx1.val;
			z1_s5  <= sz1.val;
			dy_s5  <= dy_s4;
			sat_s5 <= sat_s4 || sx1.clipped || sz1.clipped;
		end
	end

	// Stage 6: offset of z1 from the centre
	always_ff @(posedge clk) begin
		if (en_s6) begin
			x1_s6  <= x1_s5;
			dy_s6  <= dy_s5;
			dz1_s6 <= {z1_s5[COORD_W-1], z1_s5} - centre_ext;
			sat_s6 <= sat_s5;
		end
	end

	// Stage 7: products for the x rotation
	always_ff @(posedge clk) begin
		if (en_s7) begin
			x1_s7  <= x1_s6;
			pyc_s7 <= dy_s6 * cos_x_q;
			pzs_s7 <= dz1_s6 * sin_x_q;
			pzc_s7 <= dz1_s6 * cos_x_q;
			pys_s7 <= dy_s6 * sin_x_q;
			sat_s7 <= sat_s6;
		end
	end

	// Stage 8: sums for the x rotation
	always_ff @(posedge clk) begin
		if (en_s8) begin
			x1_s8  <= x1_s7;
			sy_s8  <= {pyc_s7[PROD_W-1], pyc_s7} + {pzs_s7[PROD_W-1], pzs_s7};
			sz_s8  <= {pzc_s7[PROD_W-1], pzc_s7} - {pys_s7[PROD_W-1], pys_s7};
			sat_s8 <= sat_s7;
		end
	end

	// Stage 9: truncate, recenter and clamp into the output register
	always_ff @(posedge clk) begin
		if (en_s9) begin
			x_s9   <= x1_s8;
			y_s9   <= sy2.val;
			z_s9   <= sz2.val;
			sat_s9 <= sat_s8 || sy2.clipped || sz2.clipped;
		end
	end

	assign m_axis_tvalid = v_s9;
	assign m_axis_tdata  = {z_s9, y_s9, x_s9};
	assign m_axis_tuser  = sat_s9;

	// Checks on the pipeline control
	`RPAC_ASSERT_IMP(a_ready_when_out_empty, clk, arst_n, !v_s9, s_axis_tready, "input stalled with empty output")
	`RPAC_ASSERT_NXT(a_stall_holds_s5, clk, arst_n, v_s5 && !en_s5, v_s5 && $stable(x1_s5) && $stable(sat_s5), "stalled stage 5 changed")
	`RPAC_ASSERT_NXT(a_item_moves_s2, clk, arst_n, v_s1 && en_s2, v_s2, "item lost between stage 1 and 2")
	`RPAC_ASSERT_NXT(a_flag_reaches_out, clk, arst_n, v_s8 && sat_s8 && en_s9, m_axis_tvalid && m_axis_tuser, "saturation flag dropped")

endmodule

/* tb/rotate_points_about_center_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Point rotation core testbench
// Streams points through the core under a series of register setups and
// checks every rotated point against a behavioral predictor.
// ----------------------------------------------------------------------------
// Each setup is written while the core is empty. A short directed part
// covers coordinate extremes, shift and rotation saturation, trig values
// beyond one, and junk in the unused register bits; random setups follow,
// mostly with atom-like coordinates and now and then full-range ones.
// Both stream sides insert random gaps and stalls, with some setups run
// back to back at full rate.
module rotate_points_about_center_core_tb;
	import rpac_pkg::*;

	localparam longint COORD_MAX = (longint'(1) <<< (COORD_W - 1)) - 1;
	localparam longint COORD_MIN = -COORD_MAX - 1;
	localparam int     DRAIN_CYCLES = 20;

	// Ordered to match {tdata, tuser}: new_z on top, new_x just above the flag
	typedef struct packed {
		logic [COORD_W-1:0] new_z;
		logic [COORD_W-1:0] new_y;
		logic [COORD_W-1:0] new_x;
		logic               saturated;
	} rotated_point_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [TDATA_W-1:0]    s_axis_tdata = '0;   // pos_x, pos_y, pos_z
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [TDATA_W-1:0]    m_axis_tdata;        // new_x, new_y, new_z
	logic                  m_axis_tuser;        // saturated

	// Shadow copy of the core's registers
	longint setup_cos_y, setup_sin_y, setup_cos_x, setup_sin_x;
	longint setup_shift_x, setup_shift_y, setup_shift_z, setup_centre;

	logic [TDATA_W-1:0] points_to_send_q[$];
	rotated_point_t     rotated_expect_q[$];

	int src_gap_max = 0;
	int snk_stall_max = 0;
	int gap_left = 0;
	int stall_left = 0;
	int mismatch_count = 0;
	int result_count = 0;

	rotate_points_about_center_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Clamp to the coordinate range, flag any clamp
	function automatic longint clamp_coord(input longint v, inout bit hit);
		if (v > COORD_MAX) begin
			hit = 1'b1;
			return COORD_MAX;
		end
		if (v < COORD_MIN) begin
			hit = 1'b1;
			return COORD_MIN;
		end
		return v;
	endfunction

	// Shift, rotate about y, then about x, all around (c, c, c)
	function automatic rotated_point_t rotate_point(input logic [TDATA_W-1:0] pt);
		rotated_point_t            r;
		logic signed [COORD_W-1:0] px, py, pz;
		longint                    c, xs, ys, zs, dx, dy, dz, x1, z1, dz1, y2, z2;
		bit                        hit;
		px = pt[COORD_W-1:0];
		py = pt[2*COORD_W-1:COORD_W];
		pz = pt[3*COORD_W-1:2*COORD_W];
		hit = 1'b0;
		c = setup_centre;
		xs = clamp_coord(longint'(px) + setup_shift_x, hit);
		ys = clamp_coord(longint'(py) + setup_shift_y, hit);
		zs = clamp_coord(longint'(pz) + setup_shift_z, hit);
		dx = xs - c;
		dz = zs - c;
		x1 = clamp_coord(c + ((dx * setup_cos_y + dz * setup_sin_y) >>> FRAC_W), hit);
		z1 = clamp_coord(c + ((dz * setup_cos_y - dx * setup_sin_y) >>> FRAC_W), hit);
		dy = ys - c;
		dz1 = z1 - c;
		y2 = clamp_coord(c + ((dy * setup_cos_x + dz1 * setup_sin_x) >>> FRAC_W), hit);
		z2 = clamp_coord(c + ((dz1 * setup_cos_x - dy * setup_sin_x) >>> FRAC_W), hit);
		r.new_x = x1[COORD_W-1:0];
		r.new_y = y2[COORD_W-1:0];
		r.new_z = z2[COORD_W-1:0];
		r.saturated = hit;
		return r;
	endfunction

	// Drive one register write and mirror it in the shadow copy
	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
		logic signed [TRIG_W-1:0]  trig;
		logic signed [COORD_W-1:0] shift;
		trig = data[TRIG_W-1:0];
		shift = data[COORD_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_COS_Y: begin
				setup_cos_y = longint'(trig);
			end
			REG_SIN_Y: begin
				setup_sin_y = longint'(trig);
			end
			REG_COS_X: begin
				setup_cos_x = longint'(trig);
			end
			REG_SIN_X: begin
				setup_sin_x = longint'(trig);
			end
			REG_SHIFT_X: begin
				setup_shift_x = longint'(shift);
			end
			REG_SHIFT_Y: begin
				setup_shift_y = longint'(shift);
			end
			REG_SHIFT_Z: begin
				setup_shift_z = longint'(shift);
			end
			default: begin
				setup_centre = data[CENTRE_W-1:0];
			end
		endcase
	endtask

	task automatic end_writes();
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic write_setup(input logic [CFG_DATA_W-1:0] cy, input logic [CFG_DATA_W-1:0] sy,
			input logic [CFG_DATA_W-1:0] cx, input logic [CFG_DATA_W-1:0] sx,
			input logic [CFG_DATA_W-1:0] hx, input logic [CFG_DATA_W-1:0] hy,
			input logic [CFG_DATA_W-1:0] hz, input logic [CFG_DATA_W-1:0] ctr);
		write_reg(REG_COS_Y, cy);
		write_reg(REG_SIN_Y, sy);
		write_reg(REG_COS_X, cx);
		write_reg(REG_SIN_X, sx);
		write_reg(REG_SHIFT_X, hx);
		write_reg(REG_SHIFT_Y, hy);
		write_reg(REG_SHIFT_Z, hz);
		write_reg(REG_CENTRE, ctr);
		end_writes();
		@(negedge clk);
	endtask

	task automatic push_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
			input logic [COORD_W-1:0] z);
		points_to_send_q.insert(points_to_send_q.size(), {z, y, x});
	endtask

	// Hold until every queued item is sent and every result is back
	task automatic wait_empty();
		while (points_to_send_q.size() != 0 || s_axis_tvalid || rotated_expect_q.size() != 0)
			@(negedge clk);
	endtask

	function automatic logic [COORD_W-1:0] pick_coord();
		logic [COORD_W-1:0] v;
		int                 sel;
		sel = $urandom_range(0, 9);
		if (sel < 7) begin
			v = $urandom_range(0, 32'h01FF_FFFF);
			return v - 32'h0100_0000;
		end
		if (sel < 9)
			return $urandom();
		case ($urandom_range(0, 3))
			0: return {1'b0, {(COORD_W-1){1'b1}}};
			1: return {1'b1, {(COORD_W-1){1'b0}}};
			2: return '0;
			default: return '1;
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_trig();
		int v;
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 7) begin
			v = $urandom_range(0, 65536);
			if ($urandom_range(0, 1) == 1)
				v = -v;
			return v;
		end
		if (sel < 9)
			return $urandom();
		case ($urandom_range(0, 4))
			0: return 32'h0001_0000;
			1: return 32'hFFFF_0000;
			2: return '0;
			3: return 32'h0001_FFFF;
			default: return 32'h0002_0000;
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_shift();
		logic [CFG_DATA_W-1:0] v;
		int                    sel;
		sel = $urandom_range(0, 19);
		if (sel < 12) begin
			v = $urandom_range(0, 32'h001F_FFFF);
			return v - 32'h0010_0000;
		end
		if (sel < 17)
			return $urandom();
		case ($urandom_range(0, 2))
			0: return {1'b0, {(COORD_W-1){1'b1}}};
			1: return {1'b1, {(COORD_W-1){1'b0}}};
			default: return '0;
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_centre();
		int sel;
		sel = $urandom_range(0, 19);
		if (sel < 12)
			return $urandom_range(0, 32'h00FF_FFFF);
		if (sel < 17)
			return $urandom();
		case ($urandom_range(0, 2))
			0: return '0;
			1: return {1'b0, {(COORD_W-1){1'b1}}};
			default: return '1;
		endcase
	endfunction

	// Source side: predict on acceptance, then present the next item after its gap
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			gap_left = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				rotated_expect_q.insert(rotated_expect_q.size(), rotate_point(s_axis_tdata));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap_left > 0) begin
					gap_left = gap_left - 1;
					s_axis_tvalid <= 1'b0;
				end else if (points_to_send_q.size() != 0) begin
					s_axis_tdata <= points_to_send_q.pop_front();
					s_axis_tvalid <= 1'b1;
					gap_left = $urandom_range(0, src_gap_max);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Sink side: check each accepted result, then stall at random
	always @(posedge clk or negedge arst_n) begin
		rotated_point_t exp_pt;
		rotated_point_t got_pt;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_left = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got_pt = {m_axis_tdata, m_axis_tuser};
				result_count = result_count + 1;
				if (rotated_expect_q.size() == 0) begin
					mismatch_count = mismatch_count + 1;
					if (mismatch_count <= 10)
						$display("ERROR: unexpected result %0d: x=%h y=%h z=%h sat=%b",
							result_count, got_pt.new_x, got_pt.new_y, got_pt.new_z,
							got_pt.saturated);
				end else begin
					exp_pt = rotated_expect_q.pop_front();
					if (got_pt.new_x !== exp_pt.new_x || got_pt.new_y !== exp_pt.new_y ||
							got_pt.new_z !== exp_pt.new_z ||
							got_pt.saturated !== exp_pt.saturated) begin
						mismatch_count = mismatch_count + 1;
						if (mismatch_count <= 10)
							$display("ERROR: result %0d: expected x=%h y=%h z=%h sat=%b, got x=%h y=%h z=%h sat=%b",
								result_count, exp_pt.new_x, exp_pt.new_y, exp_pt.new_z,
								exp_pt.saturated, got_pt.new_x, got_pt.new_y,
								got_pt.new_z, got_pt.saturated);
					end
				end
				stall_left = $urandom_range(0, snk_stall_max);
			end else if (stall_left > 0) begin
				stall_left = stall_left - 1;
			end
			m_axis_tready <= (stall_left == 0);
		end
	end

	initial begin
		int n;
		int i;
		setup_cos_y = longint'(1) <<< FRAC_W;
		setup_sin_y = 0;
		setup_cos_x = longint'(1) <<< FRAC_W;
		setup_sin_x = 0;
		setup_shift_x = 0;
		setup_shift_y = 0;
		setup_shift_z = 0;
		setup_centre = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset setup is the identity: extremes pass through unclamped
		push_point('0, '0, '0);
		push_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		push_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		push_point(32'h0000_0001, 32'hFFFF_FFFF, 32'h0001_0000);
		push_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_5555);
		wait_empty();

		// Shifts at the extremes clamp on every axis
		write_setup(32'h0001_0000, '0, 32'h0001_0000, '0,
			32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, '0);
		push_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
		push_point(32'h8000_0000, 32'h7FFF_FFFF, '0);
		push_point(32'h0000_0001, 32'hFFFF_FFFF, 32'h5555_AAAA);
		wait_empty();

		// Trig beyond one, junk above the register widths, largest centre
		write_setup(32'hABC1_FFFF, 32'h5556_0000, 32'hFFFF_0000, 32'h0001_0000,
			'0, '0, '0, 32'hFFFF_FFFF);
		push_point('0, '0, '0);
		push_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		push_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		push_point(32'h7FFF_FFFF, 32'h8000_0000, '0);
		push_point(32'h1234_5678, 32'h9ABC_DEF0, 32'h0FED_CBA9);
		wait_empty();

		// Fractional trig: products truncate toward minus infinity
		write_setup(32'd46341, 32'd46341, 32'd56756, 32'hFFFF_8000,
			32'h0001_0000, 32'hFFFF_8000, '0, 32'h0010_0000);
		push_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_point(32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
		push_point(32'h0003_0000, 32'hFFFD_8000, 32'h0000_1234);
		push_point(32'h000F_FFFF, 32'h0010_0001, 32'h0010_0000);
		wait_empty();

		// Random setups with random points, idling varied per setup
		for (n = 0; n < 12; n++) begin
			write_setup(pick_trig(), pick_trig(), pick_trig(), pick_trig(),
				pick_shift(), pick_shift(), pick_shift(), pick_centre());
			case (n % 4)
				0: begin
					src_gap_max = 0;
					snk_stall_max = 0;
				end
				1: begin
					src_gap_max = 15;
					snk_stall_max = 3;
				end
				2: begin
					src_gap_max = 3;
					snk_stall_max = 15;
				end
				default: begin
					src_gap_max = 15;
					snk_stall_max = 15;
				end
			endcase
			for (i = 0; i < 111; i++)
				push_point(pick_coord(), pick_coord(), pick_coord());
			wait_empty();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && rotated_expect_q.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Stop a hung run
	initial begin
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
